/* rtl/core/rfd_pkg.sv */
// Shared types, constants and the CRC-16 byte update for the response frame deframer.
package rfd_pkg;

    localparam logic [15:0] CRC_SEED       = 16'hFFFF;
    localparam logic [15:0] CRC_POLY       = 16'hA001;
    localparam logic [7:0]  TYPE_ACK       = 8'h01;
    localparam logic [7:0]  TYPE_NACK      = 8'h00;
    localparam logic [8:0]  ACK_LEN        = 9'd5;
    localparam logic [8:0]  NACK_LEN       = 9'd6;
    localparam logic [8:0]  FRAME_OVERHEAD = 9'd5;
    localparam logic [8:0]  MAX_LEN        = 9'd260;
    localparam logic [7:0]  MIN_READ_LEN   = 8'd4;
    localparam logic [7:0]  PREAMBLE_RESET = 8'hAA;
    localparam logic [7:0]  READ_CMD_RESET = 8'h09;

    // Byte positions inside a frame that carry captured payload.
    localparam logic [8:0]  POS_TYPE       = 9'd1;
    localparam logic [8:0]  POS_THIRD      = 9'd2;
    localparam logic [8:0]  POS_ERROR      = 9'd3;
    localparam logic [8:0]  POS_VALUE_LO   = 9'd5;
    localparam logic [8:0]  POS_VALUE_HI   = 9'd6;

    typedef enum logic [1:0] {
        PH_HUNT,
        PH_HEADER,
        PH_BODY
    } t_phase;

    typedef enum logic [2:0] {
        ST_READ_OK,
        ST_ACK,
        ST_NACK,
        ST_OTHER,
        ST_CRC_BAD,
        ST_SHORT_READ
    } t_status;

    typedef enum logic {
        CFG_PREAMBLE,
        CFG_READ_CMD
    } t_cfg_index;

    typedef struct packed {
        t_status     frame_status;
        logic [7:0]  frame_type;
        logic [7:0]  third_field;
        logic [15:0] register_value;
        logic [7:0]  nack_error;
        logic [8:0]  frame_length;
    } t_result;

    // Reflected CRC-16 update over one byte, eight shift steps.
    function automatic logic [15:0] crc_add(input logic [15:0] crc, input logic [7:0] b);
        logic [15:0] c;
        c = crc ^ {8'h00, b};
        for (int k = 0; k < 8; k++) begin
            if (c[0]) begin
                c = (c >> 1) ^ CRC_POLY;
            end else begin
                c = c >> 1;
            end
        end
        return c;
    endfunction

endpackage

/* rtl/core/rfd_byte_if.sv */
// Handshake channel that carries one received byte per word.
interface rfd_byte_if;
    logic       valid;
    logic       ready;
    logic [7:0] rx_byte;

    modport source (output valid, output rx_byte, input ready);
    modport sink   (input valid, input rx_byte, output ready);
endinterface

/* rtl/core/rfd_result_if.sv */
// Handshake channel that carries one decoded frame result per word.
interface rfd_result_if import rfd_pkg::*; ();
    logic    valid;
    logic    ready;
    t_result data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

/* rtl/core/rfd_cfg_if.sv */
// Configuration write channel: register index and write data per word.
interface rfd_cfg_if import rfd_pkg::*; ();
    logic       valid;
    logic       ready;
    t_cfg_index index;
    logic [7:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* rtl/core/response_frame_deframer.sv */
// Response frame deframer: preamble hunt, length decode, CRC-16 check and result report.
// The last byte word of a frame waits in the input register; its result is loaded into the
// output register when that byte is consumed, and leaves it once o_res.ready is high.
// Throughput: one byte word per cycle, set by the single registered pass through the CRC
// update; a waiting result stalls input only when the next byte also ends a frame.
// Reset (synchronous, active low): registers empty, hunting, preamble 0xAA, read code 0x09.
module response_frame_deframer import rfd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    rfd_byte_if.sink  i_rx,
    rfd_cfg_if.sink   i_cfg,
    rfd_result_if.source o_res
);

    // Configuration registers.
    logic [7:0]  r_preamble;
    logic [7:0]  r_read_cmd;

    // Input register.
    logic        r_in_valid;
    logic [7:0]  r_in_byte;

    // Frame state.
    t_phase      r_phase,     n_phase;
    logic [8:0]  r_pos,       n_pos;
    logic [7:0]  r_type,      n_type;
    logic [7:0]  r_third,     n_third;
    logic [15:0] r_crc,       n_crc;
    logic [15:0] r_value,     n_value;
    logic [7:0]  r_error,     n_error;
    logic [7:0]  r_crc_low,   n_crc_low;

    // Output register.
    logic        r_out_valid;
    t_result     r_out,       n_out;
    logic        n_out_load;

    logic        w_advance;
    logic [8:0]  w_len;
    logic [9:0]  w_pos_p2;
    logic [15:0] w_expected;

    // The byte in the input register is consumed whenever it does not end a frame, or
    // the output register is free or is being emptied in this cycle, so a waiting result
    // never blocks the stream until a second result would need the same slot.
    assign w_advance  = r_in_valid && (!n_out_load || !r_out_valid || o_res.ready);
    assign i_rx.ready = !r_in_valid || w_advance;
    assign i_cfg.ready = 1'b1;

    assign o_res.valid = r_out_valid;
    assign o_res.data  = r_out;

    // Configuration is to be written only while the block is idle; the block does not enforce it.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_preamble <= PREAMBLE_RESET;
            r_read_cmd <= READ_CMD_RESET;
        end else if (i_cfg.valid) begin
            case (i_cfg.index)
                CFG_PREAMBLE: r_preamble <= i_cfg.data;
                CFG_READ_CMD: r_read_cmd <= i_cfg.data;
                default:      r_preamble <= r_preamble;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (i_rx.ready) begin
            r_in_valid <= i_rx.valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_rx.ready && i_rx.valid) begin
            r_in_byte <= i_rx.rx_byte;
        end
    end

    // Frame length follows from the type byte; ACK and NACK frames have fixed sizes
    // and ignore the length byte.
    always_comb begin
        if (r_type == TYPE_ACK) begin
            w_len = ACK_LEN;
        end else if (r_type == TYPE_NACK) begin
            w_len = NACK_LEN;
        end else begin
            w_len = FRAME_OVERHEAD + {1'b0, r_third};
        end
    end

    assign w_pos_p2   = {1'b0, r_pos} + 10'd2;
    assign w_expected = {r_in_byte, r_crc_low};

    always_comb begin
        n_phase    = r_phase;
        n_pos      = r_pos;
        n_type     = r_type;
        n_third    = r_third;
        n_crc      = r_crc;
        n_value    = r_value;
        n_error    = r_error;
        n_crc_low  = r_crc_low;
        n_out_load = 1'b0;

        n_out.frame_status   = ST_OTHER;
        n_out.frame_type     = r_type;
        n_out.third_field    = r_third;
        n_out.register_value = 16'h0000;
        n_out.nack_error     = 8'h00;
        n_out.frame_length   = w_len;

        case (r_phase)
            PH_HEADER: begin
                n_crc = crc_add(r_crc, r_in_byte);
                if (r_pos == POS_TYPE) begin
                    n_type = r_in_byte;
                    n_pos  = POS_THIRD;
                end else begin
                    n_third = r_in_byte;
                    n_pos   = POS_ERROR;
                    n_phase = PH_BODY;
                end
            end
            PH_BODY: begin
                if (w_pos_p2 < {1'b0, w_len}) begin
                    // Payload byte: covered by the CRC, some positions are captured.
                    n_crc = crc_add(r_crc, r_in_byte);
                    if (r_pos == POS_ERROR) begin
                        n_error = r_in_byte;
                    end
                    if (r_pos == POS_VALUE_LO) begin
                        n_value = {r_value[15:8], r_in_byte};
                    end else if (r_pos == POS_VALUE_HI) begin
                        n_value = {r_in_byte, r_value[7:0]};
                    end
                    n_pos = r_pos + 9'd1;
                end else if (w_pos_p2 == {1'b0, w_len}) begin
                    // Low byte of the transmitted CRC.
                    n_crc_low = r_in_byte;
                    n_pos     = r_pos + 9'd1;
                end else begin
                    // Last byte: check the CRC and report the frame.
                    n_out_load = 1'b1;
                    if (w_expected != r_crc) begin
                        n_out.frame_status = ST_CRC_BAD;
                    end else if (r_type == TYPE_ACK) begin
                        n_out.frame_status = ST_ACK;
                    end else if (r_type == TYPE_NACK) begin
                        n_out.frame_status = ST_NACK;
                        n_out.nack_error   = r_error;
                    end else if (r_type == r_read_cmd) begin
                        if (r_third < MIN_READ_LEN) begin
                            n_out.frame_status = ST_SHORT_READ;
                        end else begin
                            n_out.frame_status   = ST_READ_OK;
                            n_out.register_value = r_value;
                        end
                    end else begin
                        n_out.frame_status = ST_OTHER;
                    end
                    n_phase = PH_HUNT;
                    n_pos   = 9'd0;
                    n_crc   = CRC_SEED;
                end
            end
            default: begin
                // Hunting, and the unused phase code behaves the same way.
                if (r_in_byte == r_preamble) begin
                    n_crc     = crc_add(CRC_SEED, r_in_byte);
                    n_pos     = POS_TYPE;
                    n_type    = 8'h00;
                    n_third   = 8'h00;
                    n_value   = 16'h0000;
                    n_error   = 8'h00;
                    n_crc_low = 8'h00;
                    n_phase   = PH_HEADER;
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase   <= PH_HUNT;
            r_pos     <= 9'd0;
            r_type    <= 8'h00;
            r_third   <= 8'h00;
            r_crc     <= CRC_SEED;
            r_value   <= 16'h0000;
            r_error   <= 8'h00;
            r_crc_low <= 8'h00;
        end else if (w_advance) begin
            r_phase   <= n_phase;
            r_pos     <= n_pos;
            r_type    <= n_type;
            r_third   <= n_third;
            r_crc     <= n_crc;
            r_value   <= n_value;
            r_error   <= n_error;
            r_crc_low <= n_crc_low;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_advance && n_out_load) begin
            r_out_valid <= 1'b1;
        end else if (o_res.ready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_advance && n_out_load) begin
            r_out <= n_out;
        end
    end

    // A reported frame always sends the deframer back to hunting.
    a_hunt_after_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_advance && n_out_load) |=> (r_phase == PH_HUNT && r_pos == 9'd0))
        else $error("deframer did not return to hunting after a frame");

    // Header decoding only ever sits at the type or the length byte.
    a_header_pos: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_phase == PH_HEADER) |-> (r_pos == POS_TYPE || r_pos == POS_THIRD))
        else $error("header phase at an unexpected byte position");

    // Register data is only reported with a good read response.
    a_value_only_on_read: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.frame_status != ST_READ_OK)
            |-> (r_out.register_value == 16'h0000))
        else $error("register value reported outside a good read response");

    // Reported length stays within the frame format.
    a_length_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid |-> (r_out.frame_length >= ACK_LEN && r_out.frame_length <= MAX_LEN))
        else $error("reported frame length out of range");

endmodule
